// ===== src/rwfg_pkg.sv =====
// ----------------------------------------------------------------------------
// rwfg_pkg
// Shared types, constants and helpers for the read window feature gather.
// ----------------------------------------------------------------------------
package rwfg_pkg;

   localparam int MAX_READ_LEN = 32768;
   localparam int MAX_FLANK    = 31;

   localparam int POS_W    = 15;
   localparam int LEN_W    = 16;
   localparam int FLANK_W  = 5;
   localparam int IDX_W    = 6;
   localparam int CODE_W   = 8;
   localparam int TAG_W    = 3;
   localparam int STORE_AW = $clog2(2 * MAX_READ_LEN);
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic CSR_READ_LENGTH = 1'b0;
   localparam logic CSR_FLANK_BASES = 1'b1;

   localparam logic [TAG_W-1:0] TAG_NONE = 3'd0;
   localparam logic [TAG_W-1:0] TAG_A    = 3'd1;
   localparam logic [TAG_W-1:0] TAG_C    = 3'd2;
   localparam logic [TAG_W-1:0] TAG_G    = 3'd3;
   localparam logic [TAG_W-1:0] TAG_T    = 3'd4;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [CODE_W-1:0] ipd;
      logic [CODE_W-1:0] pw;
   } rwfg_entry_type;

   typedef struct packed {
      logic [LEN_W-1:0]   read_len;
      logic [FLANK_W-1:0] flank;
   } rwfg_cfg_type;

   typedef enum logic {
      ST_IDLE,
      ST_QUERY
   } rwfg_state_type;

   function automatic logic [TAG_W-1:0] base_tag(input logic [7:0] ch);
      logic [TAG_W-1:0] tag;
      unique case (ch)
         8'h41, 8'h61:               tag = TAG_A;
         8'h43, 8'h63:               tag = TAG_C;
         8'h47, 8'h67:               tag = TAG_G;
         8'h54, 8'h74, 8'h55, 8'h75: tag = TAG_T;
         default:                    tag = TAG_NONE;
      endcase
      return tag;
   endfunction

   function automatic logic [STORE_AW-1:0] store_addr(input logic strand,
                                                       input logic [POS_W-1:0] pos);
      logic [STORE_AW-1:0] addr;
      addr = STORE_AW'(pos);
      if (strand) begin
         addr = STORE_AW'(MAX_READ_LEN) + STORE_AW'(pos);
      end
      return addr;
   endfunction

endpackage

// ===== src/rwfg_store.sv =====
// ----------------------------------------------------------------------------
// rwfg_store
// Read store for both strands: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rwfg_store
   import rwfg_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [STORE_AW-1:0] wr_addr,
   input  rwfg_entry_type      wr_data,
   input  logic                rd_en,
   input  logic [STORE_AW-1:0] rd_addr,
   output rwfg_entry_type      rd_data
);

   rwfg_entry_type mem [2 * MAX_READ_LEN];
   rwfg_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rwfg_csr.sv =====
// ----------------------------------------------------------------------------
// rwfg_csr
// APB register file: read length and flank, saturated for the datapath.
// ----------------------------------------------------------------------------
module rwfg_csr
   import rwfg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output rwfg_cfg_type      cfg
);

   logic [LEN_W-1:0]   read_length_ff;
   logic [FLANK_W-1:0] flank_bases_ff;
   logic               wr_en;
   logic               reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_length_ff <= LEN_W'(1);
         flank_bases_ff <= FLANK_W'(7);
      end else if (wr_en) begin
         unique case (reg_idx)
            CSR_READ_LENGTH: read_length_ff <= pwdata[LEN_W-1:0];
            CSR_FLANK_BASES: flank_bases_ff <= pwdata[FLANK_W-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_READ_LENGTH: prdata = CSR_DW'(read_length_ff);
         CSR_FLANK_BASES: prdata = CSR_DW'(flank_bases_ff);
         default:         prdata = '0;
      endcase
   end

   always_comb begin
      cfg.read_len = read_length_ff;
      if (32'(read_length_ff) > MAX_READ_LEN) begin
         cfg.read_len = LEN_W'(MAX_READ_LEN);
      end
      cfg.flank = flank_bases_ff;
      if (32'(flank_bases_ff) > MAX_FLANK) begin
         cfg.flank = FLANK_W'(MAX_FLANK);
      end
   end

endmodule

// ===== src/rwfg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwfg_ctrl
// Item sequencer: writes loads, walks query windows over the store, formats
// results from the registered read data.
// ----------------------------------------------------------------------------
module rwfg_ctrl
   import rwfg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rwfg_cfg_type        cfg,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic                req_strand,
   input  logic [POS_W-1:0]    req_position,
   input  logic [7:0]          req_base_char,
   input  logic [CODE_W-1:0]   req_ipd_code,
   input  logic [CODE_W-1:0]   req_pw_code,
   output logic                wr_en,
   output logic [STORE_AW-1:0] wr_addr,
   output rwfg_entry_type      wr_data,
   output logic                rd_en,
   output logic [STORE_AW-1:0] rd_addr,
   input  rwfg_entry_type      rd_data,
   output logic                rsp_valid,
   output logic                rsp_hot_a,
   output logic                rsp_hot_c,
   output logic                rsp_hot_g,
   output logic                rsp_hot_t,
   output logic [CODE_W-1:0]   rsp_ipd_out,
   output logic [CODE_W-1:0]   rsp_pw_out,
   output logic [IDX_W-1:0]    rsp_window_index,
   output logic                rsp_last_entry,
   output logic                rsp_offset_error
);

   rwfg_state_type state_ff, state_in;

   logic signed [POS_W+1:0] wpos_ff, wpos_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [IDX_W-1:0]        k_last_ff, k_last_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    strand_ff, strand_in;

   logic                    out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]        out_idx_ff, out_idx_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_err_ff, out_err_in;

   logic                    accept;
   logic                    is_query;
   logic                    bad_offset;
   logic                    issue;
   logic                    issue_last;
   logic [LEN_W-1:0]        len_m1;
   logic [POS_W-1:0]        clamp_pos;

   assign accept     = start && !busy;
   assign is_query   = (req_func == FUNC_QUERY);
   assign bad_offset = ({1'b0, req_position} >= cfg.read_len);
   assign issue_last = (k_ff == k_last_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_query && !bad_offset) begin
               state_in = ST_QUERY;
            end
         end
         ST_QUERY: begin
            if (issue_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            busy  = 1'b0;
            issue = 1'b0;
         end
         ST_QUERY: begin
            busy  = 1'b1;
            issue = 1'b1;
         end
         default: begin
            busy  = 1'b1;
            issue = 1'b0;
         end
      endcase
   end

   // load path
   assign wr_en       = accept && !is_query && (32'(req_position) < MAX_READ_LEN);
   assign wr_addr     = store_addr(req_strand, req_position);
   assign wr_data.tag = base_tag(req_base_char);
   assign wr_data.ipd = req_ipd_code;
   assign wr_data.pw  = req_pw_code;

   // window position clamp
   assign len_m1 = len_ff - LEN_W'(1);

   always_comb begin
      clamp_pos = wpos_ff[POS_W-1:0];
      if (wpos_ff[POS_W+1]) begin
         clamp_pos = '0;
      end else if (wpos_ff[POS_W:0] > len_m1) begin
         clamp_pos = len_m1[POS_W-1:0];
      end
   end

   assign rd_en   = issue;
   assign rd_addr = store_addr(strand_ff, clamp_pos);

   // window walk
   always_comb begin
      wpos_in   = wpos_ff;
      k_in      = k_ff;
      k_last_in = k_last_ff;
      len_in    = len_ff;
      strand_in = strand_ff;
      if (accept && is_query) begin
         wpos_in   = $signed({2'b00, req_position}) - $signed((POS_W+2)'(cfg.flank));
         k_in      = '0;
         k_last_in = {cfg.flank, 1'b0};
         len_in    = cfg.read_len;
         strand_in = req_strand;
      end else if (issue) begin
         wpos_in = wpos_ff + (POS_W+2)'(1);
         k_in    = k_ff + IDX_W'(1);
      end
   end

   // result stage, aligned with read data
   always_comb begin
      out_valid_in = 1'b0;
      out_idx_in   = k_ff;
      out_last_in  = issue_last;
      out_err_in   = 1'b0;
      if (issue) begin
         out_valid_in = 1'b1;
      end else if (accept && is_query && bad_offset) begin
         out_valid_in = 1'b1;
         out_idx_in   = '0;
         out_last_in  = 1'b1;
         out_err_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wpos_ff    <= wpos_in;
      k_ff       <= k_in;
      k_last_ff  <= k_last_in;
      len_ff     <= len_in;
      strand_ff  <= strand_in;
      out_idx_ff <= out_idx_in;
      out_last_ff <= out_last_in;
      out_err_ff <= out_err_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hot_a        = !out_err_ff && (rd_data.tag == TAG_A);
   assign rsp_hot_c        = !out_err_ff && (rd_data.tag == TAG_C);
   assign rsp_hot_g        = !out_err_ff && (rd_data.tag == TAG_G);
   assign rsp_hot_t        = !out_err_ff && (rd_data.tag == TAG_T);
   assign rsp_ipd_out      = out_err_ff ? '0 : rd_data.ipd;
   assign rsp_pw_out       = out_err_ff ? '0 : rd_data.pw;
   assign rsp_window_index = out_idx_ff;
   assign rsp_last_entry   = out_last_ff;
   assign rsp_offset_error = out_err_ff;

endmodule

// ===== src/read_window_feature_gather.sv =====
// ----------------------------------------------------------------------------
// read_window_feature_gather
// Two-strand read store with windowed gather of base one-hot and kinetic codes.
//
//   channel   handshake                  payload
//   req_      start / busy               func strand position base_char ipd pw
//   rsp_      rsp_valid (one cycle)      hot_a..t ipd pw window_index last err
//   csr       psel penable pwrite pready read_length (0x0), flank_bases (0x4)
//
// A load is written when accepted; busy stays low. A query holds busy while
// it walks its 2F+1 window entries, one store read per cycle on the single
// read port; no new item is accepted until busy drops. The first result comes
// from the read issued in the query state, via the store's read register,
// then one result per cycle. A rejected offset gives its single result the
// cycle after accept, with busy low. Synchronous reset clears control state and
// resets registers, not store contents. The receiver cannot hold results off.
// ----------------------------------------------------------------------------
module read_window_feature_gather
   import rwfg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_func,
   input  logic              req_strand,
   input  logic [POS_W-1:0]  req_position,
   input  logic [7:0]        req_base_char,
   input  logic [CODE_W-1:0] req_ipd_code,
   input  logic [CODE_W-1:0] req_pw_code,
   output logic              rsp_valid,
   output logic              rsp_hot_a,
   output logic              rsp_hot_c,
   output logic              rsp_hot_g,
   output logic              rsp_hot_t,
   output logic [CODE_W-1:0] rsp_ipd_out,
   output logic [CODE_W-1:0] rsp_pw_out,
   output logic [IDX_W-1:0]  rsp_window_index,
   output logic              rsp_last_entry,
   output logic              rsp_offset_error,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   rwfg_cfg_type        cfg;
   logic                wr_en;
   logic [STORE_AW-1:0] wr_addr;
   rwfg_entry_type      wr_data;
   logic                rd_en;
   logic [STORE_AW-1:0] rd_addr;
   rwfg_entry_type      rd_data;

   rwfg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rwfg_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rwfg_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_strand       (req_strand),
      .req_position     (req_position),
      .req_base_char    (req_base_char),
      .req_ipd_code     (req_ipd_code),
      .req_pw_code      (req_pw_code),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_hot_a        (rsp_hot_a),
      .rsp_hot_c        (rsp_hot_c),
      .rsp_hot_g        (rsp_hot_g),
      .rsp_hot_t        (rsp_hot_t),
      .rsp_ipd_out      (rsp_ipd_out),
      .rsp_pw_out       (rsp_pw_out),
      .rsp_window_index (rsp_window_index),
      .rsp_last_entry   (rsp_last_entry),
      .rsp_offset_error (rsp_offset_error)
   );

endmodule

// ===== src/rwfg_checker.sv =====
// ----------------------------------------------------------------------------
// rwfg_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rwfg_checker
   import rwfg_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_hot_a,
   input logic             rsp_hot_c,
   input logic             rsp_hot_g,
   input logic             rsp_hot_t,
   input logic [IDX_W-1:0] rsp_window_index,
   input logic             rsp_last_entry,
   input logic             rsp_offset_error
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or result right after reset");

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_hot_a, rsp_hot_c, rsp_hot_g, rsp_hot_t}))
      else $error("base one-hot has more than one bit set");

   a_err_sole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_offset_error |->
         rsp_last_entry && (rsp_window_index == '0) &&
         !rsp_hot_a && !rsp_hot_c && !rsp_hot_g && !rsp_hot_t)
      else $error("offset error result is not a lone empty last item");

   a_window_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_entry |=>
         rsp_valid && (rsp_window_index == $past(rsp_window_index) + IDX_W'(1)))
      else $error("window items not back to back in index order");

endmodule

bind read_window_feature_gather rwfg_checker u_rwfg_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_hot_a        (rsp_hot_a),
   .rsp_hot_c        (rsp_hot_c),
   .rsp_hot_g        (rsp_hot_g),
   .rsp_hot_t        (rsp_hot_t),
   .rsp_window_index (rsp_window_index),
   .rsp_last_entry   (rsp_last_entry),
   .rsp_offset_error (rsp_offset_error)
);

// ===== sim/read_window_feature_gather_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_window_feature_gather_checker
// Watches the request, result and register ports of the read window gather.
// Keeps its own copy of both strand stores and of the two registers, works
// out every window entry a query must return, and compares each result
// strobe field by field against the oldest outstanding entry.
// ----------------------------------------------------------------------------
module read_window_feature_gather_checker
   import rwfg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic              req_func,
   input  logic              req_strand,
   input  logic [POS_W-1:0]  req_position,
   input  logic [7:0]        req_base_char,
   input  logic [CODE_W-1:0] req_ipd_code,
   input  logic [CODE_W-1:0] req_pw_code,
   input  logic              rsp_valid,
   input  logic              rsp_hot_a,
   input  logic              rsp_hot_c,
   input  logic              rsp_hot_g,
   input  logic              rsp_hot_t,
   input  logic [CODE_W-1:0] rsp_ipd_out,
   input  logic [CODE_W-1:0] rsp_pw_out,
   input  logic [IDX_W-1:0]  rsp_window_index,
   input  logic              rsp_last_entry,
   input  logic              rsp_offset_error,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output int unsigned       pending_results,
   output int unsigned       mismatch_count,
   output int unsigned       results_checked,
   output int unsigned       rejects_seen
);

   typedef struct packed {
      logic              hot_a;
      logic              hot_c;
      logic              hot_g;
      logic              hot_t;
      logic [CODE_W-1:0] ipd;
      logic [CODE_W-1:0] pw;
      logic [IDX_W-1:0]  index;
      logic              last;
      logic              err;
   } window_entry_type;

   rwfg_entry_type     strand_copy [0:2*MAX_READ_LEN-1];
   window_entry_type   awaited_entries [$];
   logic [LEN_W-1:0]   read_len_reg;
   logic [FLANK_W-1:0] flank_reg;

   initial begin
      for (int i = 0; i < 2 * MAX_READ_LEN; i++) begin
         strand_copy[i] = '0;
      end
      pending_results = 0;
      mismatch_count  = 0;
      results_checked = 0;
      rejects_seen    = 0;
      read_len_reg    = 1;
      flank_reg       = 7;
   end

   function automatic logic [TAG_W-1:0] letter_tag(input logic [7:0] ch);
      case (ch)
         "A", "a":           return TAG_A;
         "C", "c":           return TAG_C;
         "G", "g":           return TAG_G;
         "T", "t", "U", "u": return TAG_T;
         default:            return TAG_NONE;
      endcase
   endfunction

   function automatic void predict_window(input logic strand, input logic [POS_W-1:0] centre);
      int unsigned   len;
      int unsigned   f;
      int unsigned   n;
      int unsigned   c;
      int unsigned   p;
      rwfg_entry_type   e;
      window_entry_type r;
      len = (read_len_reg > MAX_READ_LEN) ? MAX_READ_LEN : read_len_reg;
      f   = (flank_reg > MAX_FLANK) ? MAX_FLANK : flank_reg;
      c   = centre;
      if (c >= len) begin
         r = '0;
         r.last = 1'b1;
         r.err  = 1'b1;
         awaited_entries.insert(awaited_entries.size(), r);
         return;
      end
      n = 2 * f + 1;
      for (int unsigned k = 0; k < n; k++) begin
         p = (c + k < f) ? 0 : c + k - f;
         if (p > len - 1) begin
            p = len - 1;
         end
         e = strand_copy[strand * MAX_READ_LEN + p];
         r.hot_a = (e.tag == TAG_A);
         r.hot_c = (e.tag == TAG_C);
         r.hot_g = (e.tag == TAG_G);
         r.hot_t = (e.tag == TAG_T);
         r.ipd   = e.ipd;
         r.pw    = e.pw;
         r.index = IDX_W'(k);
         r.last  = (k + 1 == n);
         r.err   = 1'b0;
         awaited_entries.insert(awaited_entries.size(), r);
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      window_entry_type got;
      window_entry_type want;
      if (reset) begin
         read_len_reg = 1;
         flank_reg    = 7;
         awaited_entries.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_AW-1:2] == CSR_READ_LENGTH) begin
               read_len_reg = pwdata[LEN_W-1:0];
            end else if (paddr[CSR_AW-1:2] == CSR_FLANK_BASES) begin
               flank_reg = pwdata[FLANK_W-1:0];
            end
         end
         if (rsp_valid) begin
            got = {rsp_hot_a, rsp_hot_c, rsp_hot_g, rsp_hot_t, rsp_ipd_out, rsp_pw_out,
                   rsp_window_index, rsp_last_entry, rsp_offset_error};
            results_checked++;
            if (awaited_entries.size() == 0) begin
               report_mismatch("result with no item outstanding", 1, 0);
            end else begin
               want = awaited_entries.pop_front();
               if (want.err) begin
                  rejects_seen++;
               end
               if (got.hot_a !== want.hot_a) report_mismatch("hot_a", got.hot_a, want.hot_a);
               if (got.hot_c !== want.hot_c) report_mismatch("hot_c", got.hot_c, want.hot_c);
               if (got.hot_g !== want.hot_g) report_mismatch("hot_g", got.hot_g, want.hot_g);
               if (got.hot_t !== want.hot_t) report_mismatch("hot_t", got.hot_t, want.hot_t);
               if (got.ipd !== want.ipd) report_mismatch("ipd_out", got.ipd, want.ipd);
               if (got.pw !== want.pw) report_mismatch("pw_out", got.pw, want.pw);
               if (got.index !== want.index) begin
                  report_mismatch("window_index", got.index, want.index);
               end
               if (got.last !== want.last) report_mismatch("last_entry", got.last, want.last);
               if (got.err !== want.err) report_mismatch("offset_error", got.err, want.err);
            end
         end
         if (start && !busy) begin
            if (req_func == FUNC_LOAD) begin
               strand_copy[req_strand * MAX_READ_LEN + req_position] =
                  {letter_tag(req_base_char), req_ipd_code, req_pw_code};
            end else begin
               predict_window(req_strand, req_position);
            end
         end
      end
      pending_results <= awaited_entries.size();
   end

endmodule

// ===== sim/read_window_feature_gather_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_window_feature_gather_test
// Drives loads and window queries into the read window gather across several
// read length and flank settings, with bursts, random sender gaps and full
// drains. Every window is loaded before it is queried; results are judged by
// the checker placed beside the block.
// ----------------------------------------------------------------------------
module read_window_feature_gather_test;
   import rwfg_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 7;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              start         = 1'b0;
   logic              req_func      = FUNC_LOAD;
   logic              req_strand    = 1'b0;
   logic [POS_W-1:0]  req_position  = '0;
   logic [7:0]        req_base_char = '0;
   logic [CODE_W-1:0] req_ipd_code  = '0;
   logic [CODE_W-1:0] req_pw_code   = '0;
   logic              psel          = 1'b0;
   logic              penable       = 1'b0;
   logic              pwrite        = 1'b0;
   logic [CSR_AW-1:0] paddr         = '0;
   logic [CSR_DW-1:0] pwdata        = '0;

   logic              busy;
   logic              rsp_valid;
   logic              rsp_hot_a;
   logic              rsp_hot_c;
   logic              rsp_hot_g;
   logic              rsp_hot_t;
   logic [CODE_W-1:0] rsp_ipd_out;
   logic [CODE_W-1:0] rsp_pw_out;
   logic [IDX_W-1:0]  rsp_window_index;
   logic              rsp_last_entry;
   logic              rsp_offset_error;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   int unsigned pending_results;
   int unsigned mismatch_count;
   int unsigned results_checked;
   int unsigned rejects_seen;

   int unsigned cycle_count    = 0;
   int unsigned idle_pct       = 0;
   int unsigned eff_len        = 1;
   int unsigned flank          = 7;
   int unsigned load_items     = 0;
   int unsigned query_items    = 0;
   int unsigned settings_used  = 1;

   bit          loaded_map [0:2*MAX_READ_LEN-1];
   logic [7:0]  base_letters [0:9] = '{"A", "C", "G", "T", "U", "a", "c", "g", "t", "u"};
   int unsigned phase_len  [NUM_PHASES] = '{40, 32768, 65535, 1, 100, 0, 0};
   int unsigned phase_flnk [NUM_PHASES] = '{7, 15, 0, 31, 1, 5, 0};
   int unsigned phase_idle [NUM_PHASES] = '{0, 55, 16, 55, 0, 16, 55};
   int unsigned phase_ops  [NUM_PHASES] = '{6, 2, 20, 10, 16, 8, 4};

   read_window_feature_gather uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_strand       (req_strand),
      .req_position     (req_position),
      .req_base_char    (req_base_char),
      .req_ipd_code     (req_ipd_code),
      .req_pw_code      (req_pw_code),
      .rsp_valid        (rsp_valid),
      .rsp_hot_a        (rsp_hot_a),
      .rsp_hot_c        (rsp_hot_c),
      .rsp_hot_g        (rsp_hot_g),
      .rsp_hot_t        (rsp_hot_t),
      .rsp_ipd_out      (rsp_ipd_out),
      .rsp_pw_out       (rsp_pw_out),
      .rsp_window_index (rsp_window_index),
      .rsp_last_entry   (rsp_last_entry),
      .rsp_offset_error (rsp_offset_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   read_window_feature_gather_checker window_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_strand       (req_strand),
      .req_position     (req_position),
      .req_base_char    (req_base_char),
      .req_ipd_code     (req_ipd_code),
      .req_pw_code      (req_pw_code),
      .rsp_valid        (rsp_valid),
      .rsp_hot_a        (rsp_hot_a),
      .rsp_hot_c        (rsp_hot_c),
      .rsp_hot_g        (rsp_hot_g),
      .rsp_hot_t        (rsp_hot_t),
      .rsp_ipd_out      (rsp_ipd_out),
      .rsp_pw_out       (rsp_pw_out),
      .rsp_window_index (rsp_window_index),
      .rsp_last_entry   (rsp_last_entry),
      .rsp_offset_error (rsp_offset_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pending_results  (pending_results),
      .mismatch_count   (mismatch_count),
      .results_checked  (results_checked),
      .rejects_seen     (rejects_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_item(input logic func, input logic strand, input int unsigned pos,
                            input logic [7:0] ch, input logic [7:0] ipd, input logic [7:0] pw);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_func      <= func;
      req_strand    <= strand;
      req_position  <= POS_W'(pos);
      req_base_char <= ch;
      req_ipd_code  <= ipd;
      req_pw_code   <= pw;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      if (func == FUNC_LOAD) begin
         load_items++;
         loaded_map[strand * MAX_READ_LEN + pos] = 1'b1;
      end else begin
         query_items++;
      end
   endtask

   // hold off until every outstanding window entry has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_results != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_AW-1:0] addr, input int unsigned value,
                                 input int unsigned width);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= ($urandom << width) | value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned len_value, input int unsigned flank_value);
      drain();
      write_register({CSR_READ_LENGTH, 2'b00}, len_value, LEN_W);
      write_register({CSR_FLANK_BASES, 2'b00}, flank_value, FLANK_W);
      eff_len = (len_value > MAX_READ_LEN) ? MAX_READ_LEN : len_value;
      flank   = flank_value;
      settings_used++;
   endtask

   task automatic random_load(input logic strand, input int unsigned pos);
      logic [7:0] ch;
      ch = ($urandom_range(9) < 7) ? base_letters[$urandom_range(9)] : 8'($urandom);
      send_item(FUNC_LOAD, strand, pos, ch, 8'($urandom), 8'($urandom));
   endtask

   // load whatever part of the clamped window is still unwritten, then query
   task automatic gather_window(input logic strand, input int unsigned pos);
      int unsigned lo;
      int unsigned hi;
      if (pos < eff_len) begin
         lo = (pos > flank) ? pos - flank : 0;
         hi = (pos + flank < eff_len) ? pos + flank : eff_len - 1;
         for (int unsigned p = lo; p <= hi; p++) begin
            if (!loaded_map[strand * MAX_READ_LEN + p]) begin
               random_load(strand, p);
            end
         end
      end
      send_item(FUNC_QUERY, strand, pos, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   function automatic int unsigned window_centre();
      int unsigned span;
      int unsigned mid;
      if (eff_len == 0) begin
         return $urandom_range(MAX_READ_LEN - 1);
      end
      span = 2 * flank + 4;
      mid  = eff_len / 2;
      case ($urandom_range(2))
         0:       return $urandom_range((eff_len - 1 < span) ? eff_len - 1 : span);
         1:       return $urandom_range((eff_len - 1 > span) ? eff_len - 1 - span : 0,
                                        eff_len - 1);
         default: return $urandom_range(mid, (mid + 48 < eff_len) ? mid + 48 : eff_len - 1);
      endcase
   endfunction

   task automatic random_op();
      int unsigned r;
      int unsigned top;
      logic        strand;
      r      = $urandom_range(99);
      strand = 1'($urandom);
      top    = (eff_len + 8 > MAX_READ_LEN - 1) ? MAX_READ_LEN - 1 : eff_len + 8;
      if (r < 4) begin
         drain();
      end else if (r < 38) begin
         if ($urandom_range(3) == 0) begin
            random_load(strand, $urandom_range(MAX_READ_LEN - 1));
         end else begin
            random_load(strand, $urandom_range(top));
         end
      end else if (r < 48 && eff_len < MAX_READ_LEN) begin
         gather_window(strand, $urandom_range(eff_len, MAX_READ_LEN - 1));
      end else begin
         gather_window(strand, window_centre());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: one-base read, window clamps to position 0 on both sides
      send_item(FUNC_LOAD, 1'b0, 0, "A", 8'hFF, 8'h00);
      send_item(FUNC_LOAD, 1'b1, 0, "g", 8'h00, 8'hFF);
      send_item(FUNC_QUERY, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_QUERY, 1'b1, 0, 8'hFF, 8'hFF, 8'hFF);
      send_item(FUNC_QUERY, 1'b0, 1, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_QUERY, 1'b1, MAX_READ_LEN - 1, 8'h00, 8'h00, 8'h00);

      // every letter in both cases plus non-base bytes, then clamped queries and one rejected offset
      configure(13, 2);
      for (int i = 0; i < 10; i++) begin
         send_item(FUNC_LOAD, 1'b0, i, base_letters[i], 8'(i * 25), 8'(255 - i * 25));
      end
      send_item(FUNC_LOAD, 1'b0, 10, "N", 8'h80, 8'h01);
      send_item(FUNC_LOAD, 1'b0, 11, 8'h00, 8'h7F, 8'hFE);
      send_item(FUNC_LOAD, 1'b0, 12, 8'hFF, 8'hFF, 8'hFF);
      send_item(FUNC_QUERY, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_QUERY, 1'b0, 6, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_QUERY, 1'b0, 12, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_QUERY, 1'b0, 13, 8'h00, 8'h00, 8'h00);

      phase_len[NUM_PHASES-1]  = $urandom_range(2, 600);
      phase_flnk[NUM_PHASES-1] = $urandom_range(MAX_FLANK);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         configure(phase_len[ph], phase_flnk[ph]);
         idle_pct = phase_idle[ph];
         repeat (phase_ops[ph]) random_op();
      end

      drain();
      repeat (2 * MAX_FLANK + 8) @(posedge clock);

      $display("%0d items: %0d loads, %0d queries (%0d rejected offsets), %0d register settings",
               load_items + query_items, load_items, query_items, rejects_seen, settings_used);
      $display("%0d window results compared, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/rwfg_pkg.sv
src/rwfg_store.sv
src/rwfg_csr.sv
src/rwfg_ctrl.sv
src/read_window_feature_gather.sv
src/rwfg_checker.sv
sim/read_window_feature_gather_checker.sv
sim/read_window_feature_gather_test.sv
